// ----- rtl/tmfc_pkg.sv -----
// ----------------------------------------------------------------------------
// tmfc_pkg
// Shared types, constants and helpers of the teleoperation motor frame
// controller: code scale, frame types, opcodes, register indexes.
// ----------------------------------------------------------------------------
package tmfc_pkg;

    // Code scale
    localparam int CODE_BITS = 16;
    localparam int CODE_MAX  = (1 << CODE_BITS) - 1;
    localparam int CODE_MID  = CODE_MAX >> 1;

    // Field widths
    localparam int OPCODE_W  = 3;
    localparam int IDENT_W   = 29;
    localparam int PAYLOAD_W = 64;
    localparam int NODE_W    = 8;
    localparam int POS_W     = 16;
    localparam int GAIN_W    = 16;
    localparam int DBAND_W   = 15;
    localparam int OFFSET_W  = POS_W + 1;
    localparam int WIDE_W    = POS_W + 2;
    localparam int TYPE_W    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Default depth of the command queue
    localparam int QUEUE_DEPTH = 2;

    // Input opcodes
    localparam logic [OPCODE_W-1:0] OP_RX      = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_TICK    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_CAPTURE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_ENABLE  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DISABLE = 3'd4;

    // Bus frame types (identifier bits 28:24)
    localparam logic [TYPE_W-1:0] TYPE_OPERATION = 5'h01;
    localparam logic [TYPE_W-1:0] TYPE_FEEDBACK  = 5'h02;
    localparam logic [TYPE_W-1:0] TYPE_ENABLE    = 5'h03;
    localparam logic [TYPE_W-1:0] TYPE_DISABLE   = 5'h04;
    localparam logic [TYPE_W-1:0] TYPE_MODE      = 5'h12;

    // Mode frame payload: run mode parameter set to operation control
    localparam logic [PAYLOAD_W-1:0] MODE_PAYLOAD = 64'h0570_0000_0000_0000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_NODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_NODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_NODE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_KP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_KD       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_KD      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_DBAND   = 3'd6;

    // Configuration register contents
    typedef struct packed {
        logic [NODE_W-1:0]  slave_node;
        logic [NODE_W-1:0]  master_node;
        logic [NODE_W-1:0]  host_node;
        logic [GAIN_W-1:0]  slave_stiffness_code;
        logic [GAIN_W-1:0]  slave_damping_code;
        logic [GAIN_W-1:0]  master_damping_code;
        logic [DBAND_W-1:0] torque_deadband_code;
    } cfg_regs_t;

    // Command handed from front to back
    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_ENABLE,
        CMD_DISABLE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [POS_W-1:0]   target;
        logic [POS_W-1:0]   torque;
    } cmd_t;

    // Saturate a widened signed value to the code range
    function automatic logic [POS_W-1:0] clamp_code(input logic signed [WIDE_W-1:0] v);
        logic [POS_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > $signed(WIDE_W'(CODE_MAX)))
        begin
            r = POS_W'(CODE_MAX);
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/tmfc_ifs.sv -----
// ----------------------------------------------------------------------------
// tmfc channel interfaces
// Valid/ready channels for input items, output frames and register writes.
// ----------------------------------------------------------------------------
interface tmfc_in_if;
    logic                              valid;
    logic                              ready;
    logic [tmfc_pkg::OPCODE_W-1:0]     opcode;
    logic [tmfc_pkg::IDENT_W-1:0]      rx_ident;
    logic [tmfc_pkg::PAYLOAD_W-1:0]    rx_payload;

    modport source (output valid, output opcode, output rx_ident, output rx_payload,
                    input ready);
    modport sink (input valid, input opcode, input rx_ident, input rx_payload,
                  output ready);
endinterface

interface tmfc_out_if;
    logic                              valid;
    logic                              ready;
    logic [tmfc_pkg::IDENT_W-1:0]      tx_ident;
    logic [tmfc_pkg::PAYLOAD_W-1:0]    tx_payload;
    logic                              last_frame;

    modport source (output valid, output tx_ident, output tx_payload, output last_frame,
                    input ready);
    modport sink (input valid, input tx_ident, input tx_payload, input last_frame,
                  output ready);
endinterface

interface tmfc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tmfc_pkg::CFG_IDX_W-1:0]    index;
    logic [tmfc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/tmfc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tmfc_cfg_regs
// Configuration register file: node numbers, gains and torque deadband.
// ----------------------------------------------------------------------------
module tmfc_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    tmfc_cfg_if.sink            cfg_wr,
    output tmfc_pkg::cfg_regs_t cfg
);

    tmfc_pkg::cfg_regs_t cfg_reg;
    tmfc_pkg::cfg_regs_t cfg_next;

    assign cfg_wr.ready = 1'b1;
    assign cfg        = cfg_reg;

    // Register write decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr.valid)
        begin
            unique case (cfg_wr.index)
                tmfc_pkg::CFG_SLAVE_NODE:
                    cfg_next.slave_node = cfg_wr.data[tmfc_pkg::NODE_W-1:0];
                tmfc_pkg::CFG_MASTER_NODE:
                    cfg_next.master_node = cfg_wr.data[tmfc_pkg::NODE_W-1:0];
                tmfc_pkg::CFG_HOST_NODE:
                    cfg_next.host_node = cfg_wr.data[tmfc_pkg::NODE_W-1:0];
                tmfc_pkg::CFG_SLAVE_KP:
                    cfg_next.slave_stiffness_code = cfg_wr.data[tmfc_pkg::GAIN_W-1:0];
                tmfc_pkg::CFG_SLAVE_KD:
                    cfg_next.slave_damping_code = cfg_wr.data[tmfc_pkg::GAIN_W-1:0];
                tmfc_pkg::CFG_MASTER_KD:
                    cfg_next.master_damping_code = cfg_wr.data[tmfc_pkg::GAIN_W-1:0];
                tmfc_pkg::CFG_TORQUE_DBAND:
                    cfg_next.torque_deadband_code = cfg_wr.data[tmfc_pkg::DBAND_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_node           <= 8'd1;
            cfg_reg.master_node          <= 8'd127;
            cfg_reg.host_node            <= 8'd253;
            cfg_reg.slave_stiffness_code <= 16'd3276;
            cfg_reg.slave_damping_code   <= 16'd13107;
            cfg_reg.master_damping_code  <= 16'd0;
            cfg_reg.torque_deadband_code <= 15'd273;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/tmfc_front.sv -----
// ----------------------------------------------------------------------------
// tmfc_front
// Accepts input items, keeps the feedback state and the captured offset,
// and turns frame-emitting items into queued commands.
// ----------------------------------------------------------------------------
module tmfc_front (
    input  logic                clk,
    input  logic                rst_n,
    tmfc_in_if.sink             cmd_in,
    input  tmfc_pkg::cfg_regs_t cfg,
    input  logic                q_full,
    output logic                q_push,
    output tmfc_pkg::cmd_t      q_wdata
);

    logic [tmfc_pkg::POS_W-1:0]           mst_pos_reg, mst_pos_next;
    logic [tmfc_pkg::POS_W-1:0]           slv_pos_reg, slv_pos_next;
    logic [tmfc_pkg::POS_W-1:0]           slave_torque_reg, slave_torque_next;
    logic signed [tmfc_pkg::OFFSET_W-1:0] offset_reg, offset_next;

    logic                                 accept;
    logic                                 is_feedback;
    logic [tmfc_pkg::NODE_W-1:0]          rx_node;
    logic signed [tmfc_pkg::WIDE_W-1:0]   target_sum;

    assign cmd_in.ready = !q_full;
    assign accept       = cmd_in.valid && cmd_in.ready;

    assign is_feedback = (cmd_in.rx_ident[28:24] == tmfc_pkg::TYPE_FEEDBACK);
    assign rx_node     = cmd_in.rx_ident[15:8];

    // Slave target: master position plus offset, saturated
    assign target_sum = $signed({2'b00, mst_pos_reg})
                      + tmfc_pkg::WIDE_W'(offset_reg);

    // State update and command classification
    always_comb
    begin
        mst_pos_next      = mst_pos_reg;
        slv_pos_next      = slv_pos_reg;
        slave_torque_next = slave_torque_reg;
        offset_next       = offset_reg;
        q_push            = 1'b0;
        q_wdata.kind      = tmfc_pkg::CMD_TICK;
        q_wdata.target    = tmfc_pkg::clamp_code(target_sum);
        q_wdata.torque    = slave_torque_reg;
        if (accept)
        begin
            unique case (cmd_in.opcode)
                tmfc_pkg::OP_RX:
                begin
                    if (is_feedback)
                    begin
                        // master wins when both node numbers match
                        if (rx_node == cfg.master_node)
                        begin
                            mst_pos_next = cmd_in.rx_payload[63:48];
                        end
                        else if (rx_node == cfg.slave_node)
                        begin
                            slv_pos_next      = cmd_in.rx_payload[63:48];
                            slave_torque_next = cmd_in.rx_payload[31:16];
                        end
                    end
                end
                tmfc_pkg::OP_TICK:
                begin
                    q_push       = 1'b1;
                    q_wdata.kind = tmfc_pkg::CMD_TICK;
                end
                tmfc_pkg::OP_CAPTURE:
                begin
                    offset_next = $signed({1'b0, slv_pos_reg})
                                - $signed({1'b0, mst_pos_reg});
                end
                tmfc_pkg::OP_ENABLE:
                begin
                    q_push       = 1'b1;
                    q_wdata.kind = tmfc_pkg::CMD_ENABLE;
                end
                tmfc_pkg::OP_DISABLE:
                begin
                    q_push       = 1'b1;
                    q_wdata.kind = tmfc_pkg::CMD_DISABLE;
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mst_pos_reg      <= tmfc_pkg::POS_W'(tmfc_pkg::CODE_MID);
            slv_pos_reg      <= tmfc_pkg::POS_W'(tmfc_pkg::CODE_MID);
            slave_torque_reg <= tmfc_pkg::POS_W'(tmfc_pkg::CODE_MID);
            offset_reg       <= '0;
        end
        else
        begin
            mst_pos_reg      <= mst_pos_next;
            slv_pos_reg      <= slv_pos_next;
            slave_torque_reg <= slave_torque_next;
            offset_reg       <= offset_next;
        end
    end

endmodule

// ----- rtl/tmfc_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// tmfc_cmd_queue
// Small circular queue of commands between the front and the back.
// ----------------------------------------------------------------------------
module tmfc_cmd_queue #(
    parameter int DEPTH = tmfc_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tmfc_pkg::cmd_t wdata,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output tmfc_pkg::cmd_t rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tmfc_pkg::cmd_t   entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign rdata   = entries[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/tmfc_back.sv -----
// ----------------------------------------------------------------------------
// tmfc_back
// Takes commands from the queue and emits their bus frames one per cycle while the
// sink is ready, through an output register.
// ----------------------------------------------------------------------------
module tmfc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tmfc_pkg::cfg_regs_t cfg,
    input  logic                q_valid,
    input  tmfc_pkg::cmd_t      q_rdata,
    output logic                q_pop,
    tmfc_out_if.source          frame_out
);

    localparam logic [tmfc_pkg::POS_W-1:0] MID16 = tmfc_pkg::POS_W'(tmfc_pkg::CODE_MID);

    tmfc_pkg::cmd_t                     cur_reg;
    logic                               cur_valid_reg, cur_valid_next;
    logic [1:0]                         idx_reg, idx_next;
    logic signed [tmfc_pkg::WIDE_W-1:0] ntq_reg, ntq_next;

    logic                               out_valid_reg, out_valid_next;
    logic [tmfc_pkg::IDENT_W-1:0]       ident_reg, ident_next;
    logic [tmfc_pkg::PAYLOAD_W-1:0]     payload_reg, payload_next;
    logic                               last_reg, last_next;

    logic                               adv;
    logic                               is_last;
    logic [1:0]                         last_idx;
    logic signed [tmfc_pkg::WIDE_W-1:0] torque_d;
    logic signed [tmfc_pkg::WIDE_W-1:0] band;
    logic signed [tmfc_pkg::WIDE_W-1:0] half;
    logic [tmfc_pkg::POS_W-1:0]         master_tq;

    assign frame_out.valid      = out_valid_reg;
    assign frame_out.tx_ident   = ident_reg;
    assign frame_out.tx_payload = payload_reg;
    assign frame_out.last_frame = last_reg;

    assign last_idx = (cur_reg.kind == tmfc_pkg::CMD_ENABLE) ? 2'd3 : 2'd1;
    assign is_last  = (idx_reg == last_idx);
    assign adv      = cur_valid_reg && (!out_valid_reg || frame_out.ready);
    assign q_pop    = q_valid && (!cur_valid_reg || (adv && is_last));

    // Negated deadbanded torque, taken while the slave frame goes out
    assign torque_d = $signed({2'b00, cur_reg.torque}) - $signed({2'b00, MID16});
    assign band     = $signed({3'b000, cfg.torque_deadband_code});

    always_comb
    begin
        if ((torque_d < band) && (torque_d > -band))
        begin
            ntq_next = '0;
        end
        else if (torque_d > 0)
        begin
            ntq_next = band - torque_d;
        end
        else
        begin
            ntq_next = -band - torque_d;
        end
    end

    // Master torque: mid plus half of the negated torque, rounded down
    assign half      = ntq_reg >>> 1;
    assign master_tq = tmfc_pkg::clamp_code($signed({2'b00, MID16}) + half);

    // Frame formation for the current command and frame index
    always_comb
    begin
        ident_next   = ident_reg;
        payload_next = payload_reg;
        last_next    = last_reg;
        if (adv)
        begin
            last_next    = is_last;
            payload_next = '0;
            case (cur_reg.kind)
                tmfc_pkg::CMD_TICK:
                begin
                    if (idx_reg == 2'd0)
                    begin
                        ident_next   = {tmfc_pkg::TYPE_OPERATION, MID16, cfg.slave_node};
                        payload_next = {cur_reg.target, MID16, cfg.slave_stiffness_code,
                                        cfg.slave_damping_code};
                    end
                    else
                    begin
                        ident_next   = {tmfc_pkg::TYPE_OPERATION, master_tq, cfg.master_node};
                        payload_next = {MID16, MID16, 16'd0, cfg.master_damping_code};
                    end
                end
                tmfc_pkg::CMD_ENABLE:
                begin
                    case (idx_reg)
                        2'd0:
                        begin
                            ident_next   = {tmfc_pkg::TYPE_MODE, 8'd0, cfg.host_node,
                                            cfg.master_node};
                            payload_next = tmfc_pkg::MODE_PAYLOAD;
                        end
                        2'd1:
                        begin
                            ident_next   = {tmfc_pkg::TYPE_ENABLE, 8'd0, cfg.host_node,
                                            cfg.master_node};
                        end
                        2'd2:
                        begin
                            ident_next   = {tmfc_pkg::TYPE_MODE, 8'd0, cfg.host_node,
                                            cfg.slave_node};
                            payload_next = tmfc_pkg::MODE_PAYLOAD;
                        end
                        default:
                        begin
                            ident_next   = {tmfc_pkg::TYPE_ENABLE, 8'd0, cfg.host_node,
                                            cfg.slave_node};
                        end
                    endcase
                end
                tmfc_pkg::CMD_DISABLE:
                begin
                    if (idx_reg == 2'd0)
                    begin
                        ident_next = {tmfc_pkg::TYPE_DISABLE, 8'd0, cfg.host_node,
                                      cfg.slave_node};
                    end
                    else
                    begin
                        ident_next = {tmfc_pkg::TYPE_DISABLE, 8'd0, cfg.host_node,
                                      cfg.master_node};
                    end
                end
                default:
                begin
                    ident_next = ident_reg;
                end
            endcase
        end
    end

    // Sequencer and output valid
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (adv)
        begin
            if (is_last)
            begin
                cur_valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end

        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (frame_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_rdata;
        end
        if (adv && idx_reg == 2'd0)
        begin
            ntq_reg <= ntq_next;
        end
        ident_reg   <= ident_next;
        payload_reg <= payload_next;
        last_reg    <= last_next;
    end

endmodule

// ----- rtl/teleop_motor_frame_controller.sv -----
// With the back idle, the first frame of a tick, enable or disable item goes from the accepting
// edge through the queue, then the command register, then the output register.
// Throughput: one frame per cycle while the sink is ready; a tick or disable item sends two
// frames, an enable item four; other items send none. The front accepts one item per cycle while
// the command queue has room.
// Reset: asynchronous, active low; control and config registers to reset values, positions and torque to mid.
// ----------------------------------------------------------------------------
// teleop_motor_frame_controller
// Master-slave motor teleoperation controller: feedback frames and capture items update state,
// ticks, enable and disable items produce bus command frames.
// ----------------------------------------------------------------------------
module teleop_motor_frame_controller #(
    parameter int QUEUE_DEPTH = tmfc_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    tmfc_in_if.sink     cmd_in,
    tmfc_out_if.source  frame_out,
    tmfc_cfg_if.sink    cfg_wr
);

    tmfc_pkg::cfg_regs_t cfg;
    tmfc_pkg::cmd_t      q_wdata;
    tmfc_pkg::cmd_t      q_rdata;
    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_valid;

    tmfc_cfg_regs u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .cfg    (cfg)
    );

    tmfc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_in  (cmd_in),
        .cfg     (cfg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    tmfc_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    tmfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .frame_out (frame_out)
    );

    // Front never pushes into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    // Back never pops an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("command popped from empty queue");

    // Frames of one item go out back to back
    a_frames_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_out.valid && frame_out.ready && !frame_out.last_frame) |=> frame_out.valid)
        else $error("gap inside a frame burst");

endmodule
